// File: sv/lcg_pkg.sv
// ----------------------------------------------------------------------------
// LCG package
// Shared types for the linear congruential random source: the request and
// response words, the opcodes and the controller-to-datapath command/status.
// ----------------------------------------------------------------------------
package lcg_pkg;

  // Generator constants.
  localparam int unsigned         LcgWidth = 32;
  localparam logic [LcgWidth-1:0] LcgMul   = 32'd1103515245;
  localparam logic [LcgWidth-1:0] LcgInc   = 32'd12345;
  localparam logic [LcgWidth-1:0] LcgSeed  = 32'd1;
  localparam int unsigned         DivCntW  = $clog2(LcgWidth);

  // Request opcodes. The fourth code is unused and returns zeros.
  typedef enum logic [1:0] {
    OP_BIT    = 2'd0,
    OP_WORD   = 2'd1,
    OP_RANGE  = 2'd2,
    OP_UNUSED = 2'd3
  } lcg_op_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_DIV,
    ST_FIN
  } lcg_state_e;

  // Request word.
  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
  } lcg_req_t;

  // Response word.
  typedef struct packed {
    logic [31:0]        word_value;
    logic signed [31:0] ranged_value;
  } lcg_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic step_lcg;
    logic div_step;
    logic load_out;
  } lcg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_range;
    logic div_last;
    logic out_free;
  } lcg_sts_t;

endpackage

// File: sv/lcg_stream_if.sv
// ----------------------------------------------------------------------------
// LCG stream interface
// Valid/ready channel that moves one word of type T per handshake.
// ----------------------------------------------------------------------------
interface lcg_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/lcg_ctrl.sv
// ----------------------------------------------------------------------------
// LCG controller
// Sequences one request: capture, generator step, optional remainder loop,
// and hand-off of the result word into the output register.
// ----------------------------------------------------------------------------
module lcg_ctrl
  import lcg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  lcg_sts_t sts_i,
  output lcg_cmd_t cmd_o
);

  lcg_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o    = 1'b1;
        cmd_o.load_req = req_valid_i;
        if (req_valid_i) begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd_o.step_lcg = 1'b1;
        state_d        = sts_i.is_range ? ST_DIV : ST_FIN;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // Wait until the output register can take the word.
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/lcg_dp.sv
// ----------------------------------------------------------------------------
// LCG datapath
// Generator state, bound ordering, radix-2 restoring remainder unit and the
// output register of the response channel.
// ----------------------------------------------------------------------------
module lcg_dp
  import lcg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  lcg_req_t req_i,
  input  lcg_cmd_t cmd_i,
  output lcg_sts_t sts_o,
  input  logic     rsp_ready_i,
  output logic     rsp_valid_o,
  output lcg_rsp_t rsp_o
);

  logic [31:0]        gen_q, gen_d;
  logic [1:0]         op_q;
  logic [31:0]        lo_q, hi_q;
  logic [31:0]        span_q;
  logic [31:0]        dvd_q;
  logic [31:0]        rem_q, rem_d;
  logic [DivCntW-1:0] cnt_q;
  logic               out_valid_q;
  lcg_rsp_t           out_q, out_d;
  logic               swap;
  logic [32:0]        rem_sh, rem_diff;

  // Generator step: multiply and add, registered right after.
  assign gen_d = gen_q * LcgMul + LcgInc;

  // Signed compare decides whether the bounds arrived reversed.
  assign swap = req_i.range_high < req_i.range_low;

  // One restoring step of the remainder.
  assign rem_sh   = {rem_q, dvd_q[31]};
  assign rem_diff = rem_sh - {1'b0, span_q};
  assign rem_d    = rem_diff[32] ? rem_sh[31:0] : rem_diff[31:0];

  // Generator state; the unused opcode leaves it unchanged.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= LcgSeed;
    end else if (cmd_i.step_lcg && (op_q != OP_UNUSED)) begin
      gen_q <= gen_d;
    end
  end

  // Request capture, span and remainder loop.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      op_q <= req_i.opcode;
      lo_q <= swap ? req_i.range_high : req_i.range_low;
      hi_q <= swap ? req_i.range_low : req_i.range_high;
    end
    if (cmd_i.step_lcg) begin
      span_q <= hi_q - lo_q + 32'd1;
      dvd_q  <= gen_d;
      rem_q  <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[30:0], 1'b0};
      rem_q <= rem_d;
      cnt_q <= cnt_q + DivCntW'(1);
    end
  end

  // Result word from the finished step.
  always_comb begin
    out_d = '0;
    case (op_q)
      OP_BIT:   out_d.word_value = {31'd0, gen_q[31]};
      OP_WORD:  out_d.word_value = gen_q;
      OP_RANGE: out_d.ranged_value = (span_q == '0) ? gen_q : lo_q + rem_q;
      default:  out_d = '0;
    endcase
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign rsp_valid_o    = out_valid_q;
  assign rsp_o          = out_q;
  assign sts_o.is_range = (op_q == OP_RANGE);
  assign sts_o.div_last = (cnt_q == DivCntW'(LcgWidth - 1));
  assign sts_o.out_free = !out_valid_q || rsp_ready_i;

endmodule

// File: sv/lcg_random_range_generator.sv
// ----------------------------------------------------------------------------
// LCG random range generator
// Sequence: an accepted range request passes the step state, the remainder
// loop of the radix-2 unit over every dividend bit and the finish state;
// other opcodes go from the step state straight to the finish state.
// Finish waits for a free output register; only then is a new request taken.
// Reset: the generator state returns to 1 and both channels go empty.
// ----------------------------------------------------------------------------
module lcg_random_range_generator
  import lcg_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  lcg_stream_if.sink   req_i,
  lcg_stream_if.source rsp_o
);

  lcg_cmd_t cmd;
  lcg_sts_t sts;
  lcg_req_t req_word;
  lcg_rsp_t rsp_word;

  assign req_word    = req_i.payload;
  assign rsp_o.payload = rsp_word;

  // Controller.
  lcg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath.
  lcg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_word),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_o       (rsp_word)
  );

  // A new word is never taken while one is still being worked on.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while busy");

  // The output register is loaded only when it is free.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!rsp_o.valid || rsp_o.ready))
    else $error("pending response overwritten");

  // The remainder loop runs only for range requests.
  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_step |-> sts.is_range)
    else $error("remainder step outside range mode");

  // At most one command is issued per cycle.
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load_req, cmd.step_lcg, cmd.div_step, cmd.load_out}))
    else $error("conflicting datapath commands");

endmodule
